// ===== rtl/core/vdlw_pkg.sv =====
// ----------------------------------------------------------------------------
// vdlw_pkg
// Shared types and constants of the vector display list writer.
// ----------------------------------------------------------------------------
package vdlw_pkg;

    localparam int COORD_W = 10;
    localparam int ADDR_W  = 10;
    localparam int WORD_W  = 16;
    localparam int DEN_W   = 10;
    localparam int SHIFT_W = 4;
    localparam int STEP_W  = 4;

    // Display list word codes, before the byte swap
    localparam logic [WORD_W-1:0] WORD_MOVE  = 16'h0400;
    localparam logic [WORD_W-1:0] WORD_JUMP  = 16'h0800;
    localparam logic [WORD_W-1:0] WORD_BLANK = 16'hffff;

    // Speed word scaling
    localparam logic [WORD_W-1:0] SPEED_LIMIT = 16'h0100;
    localparam logic [WORD_W-1:0] SMALL_LIMIT = 16'h0020;
    localparam logic [DEN_W-1:0]  SMALL_DEN   = 10'h100;
    localparam logic [SHIFT_W-1:0] NORM_MSB   = 4'd15;
    localparam logic [STEP_W-1:0]  DIV_LAST   = 4'd15;

    // Word slots of one command
    localparam logic [1:0] SWAP_LAST_IDX = 2'd1;
    localparam logic [1:0] CMD_LAST_IDX  = 2'd3;
    localparam logic [1:0] IDX_MOVE      = 2'd0;
    localparam logic [1:0] IDX_BEAM      = 2'd1;
    localparam logic [1:0] IDX_SPEED_X   = 2'd2;

    typedef enum logic [1:0] {
        OP_MOVE = 2'd0,
        OP_LINE = 2'd1,
        OP_SWAP = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_DIV,
        S_SHR,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       take;
        logic       norm;
        logic       load_quot;
        logic       shr_step;
        logic       emit;
        logic       last;
        logic [1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       div_busy;
        logic       shr_done;
        logic       out_free;
    } t_sts;

endpackage

// ===== rtl/core/vector_display_list_writer.sv =====
// ----------------------------------------------------------------------------
// vector_display_list_writer
// Turns move / line / swap requests into byte-swapped display list words,
// each with its byte address in a double-buffered display memory.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ------------------------------
//  in        sink       i_in_valid / o_in_ready    i_operation, i_x, i_y
//  out       source     o_out_valid / i_out_ready  o_address, o_word, o_last
//
// Sequence: one request at a time. A move is accepted, then emits 4 words; a
// swap emits 2. A line is accepted, normalized, divided by the 16-step
// divider, its quotient loaded, and the speed pair shifted right (at most
// 11 shifts) before its 4 words go out. An unused operation code is taken
// and dropped.
// Reset: synchronous, active low; clears pen, frame select and both write
// positions (frame 1 restarts at FRAME_BYTES). No clearing pass.
// Stalls: a word waits in the output register while i_out_ready is low; the
// next word holds in the controller. Input ready returns once the final word
// of a request is loaded, even if it has not been taken yet.
//
module vector_display_list_writer #(
    parameter int FRAME_BYTES = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_operation,
    input  logic [vdlw_pkg::COORD_W-1:0] i_x,
    input  logic [vdlw_pkg::COORD_W-1:0] i_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [vdlw_pkg::ADDR_W-1:0]  o_address,
    output logic [vdlw_pkg::WORD_W-1:0]  o_word,
    output logic                         o_last
);
    import vdlw_pkg::*;

    // Command from controller to datapath, status back
    t_cmd cmd;
    t_sts sts;

    // Sequence each request: accept, then for lines normalize / divide /
    // scale down, then hand words to the output register one at a time.
    vdlw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Hold pen, frame and write positions; compute speed words; drive outputs.
    vdlw_dp #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_operation (i_operation),
        .i_x         (i_x),
        .i_y         (i_y),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_address   (o_address),
        .o_word      (o_word),
        .o_last      (o_last)
    );

endmodule

// ===== rtl/core/vdlw_div.sv =====
// ----------------------------------------------------------------------------
// vdlw_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vdlw_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [vdlw_pkg::WORD_W-1:0] i_num,
    input  logic [vdlw_pkg::DEN_W-1:0]  i_den,
    output logic                        o_busy,
    output logic [vdlw_pkg::WORD_W-1:0] o_quot
);
    import vdlw_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [WORD_W-1:0] r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;

    logic [DEN_W:0]    rem_sh;
    logic              q_bit;
    logic [DEN_W-1:0]  n_rem;

    always_comb begin
        rem_sh = {r_rem, r_num[WORD_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_den});
        if (q_bit) begin
            n_rem = DEN_W'(rem_sh - {1'b0, r_den});
        end else begin
            n_rem = rem_sh[DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[WORD_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;

endmodule

// ===== rtl/core/vdlw_dp.sv =====
// ----------------------------------------------------------------------------
// vdlw_dp
// Datapath: pen, frame and write positions, speed computation, output register.
// ----------------------------------------------------------------------------
module vdlw_dp #(
    parameter int FRAME_BYTES = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vdlw_pkg::t_cmd               i_cmd,
    output vdlw_pkg::t_sts               o_sts,
    input  logic [1:0]                   i_operation,
    input  logic [vdlw_pkg::COORD_W-1:0] i_x,
    input  logic [vdlw_pkg::COORD_W-1:0] i_y,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [vdlw_pkg::ADDR_W-1:0]  o_address,
    output logic [vdlw_pkg::WORD_W-1:0]  o_word,
    output logic                         o_last
);
    import vdlw_pkg::*;

    localparam logic [ADDR_W-1:0] BASE1 = ADDR_W'(FRAME_BYTES);
    localparam logic [ADDR_W:0]   FSIZE = (ADDR_W + 1)'(FRAME_BYTES);

    // Command and pen state
    logic [1:0]         r_op;
    logic [COORD_W-1:0] r_x, r_y;
    logic [COORD_W-1:0] r_dx, r_dy;
    logic [COORD_W-1:0] r_pen_x, r_pen_y;
    logic               r_frame;
    logic [ADDR_W-1:0]  r_wp0, r_wp1;

    // Speed state
    logic               r_xg;
    logic [DEN_W-1:0]   r_d;
    logic [WORD_W-1:0]  r_hi, r_lo;

    // Output register
    logic               r_out_valid;
    logic [ADDR_W-1:0]  r_address;
    logic [WORD_W-1:0]  r_word;
    logic               r_last;

    logic [COORD_W-1:0] dx, dy;
    logic               xg;
    logic [COORD_W-1:0] hi0, lo0;
    logic [SHIFT_W-1:0] msb, sh;
    logic [WORD_W-1:0]  num;
    logic [WORD_W-1:0]  quot;
    logic               div_busy;
    logic [WORD_W-1:0]  thr;
    logic               shr_done;
    logic [WORD_W-1:0]  lo_f, sx, sy;
    logic [ADDR_W-1:0]  wp, base, off, wp_next;
    logic [ADDR_W:0]    off2;
    logic [WORD_W-1:0]  raw;

    assign dx = (i_x > r_pen_x) ? i_x - r_pen_x : r_pen_x - i_x;
    assign dy = (i_y > r_pen_y) ? i_y - r_pen_y : r_pen_y - i_y;

    // Normalize: larger delta up to bit 15; smaller delta equals the divisor,
    // so its quotient is the shift as a power of two.
    always_comb begin
        xg  = (r_dx > r_dy);
        hi0 = xg ? r_dx : r_dy;
        lo0 = xg ? r_dy : r_dx;
        if (hi0 == '0) begin
            hi0 = COORD_W'(1);
        end
        if (lo0 == '0) begin
            lo0 = hi0;
        end
        msb = '0;
        for (int i = 0; i < COORD_W; i++) begin
            if (hi0[i]) begin
                msb = SHIFT_W'(i);
            end
        end
        sh  = NORM_MSB - msb;
        num = WORD_W'(hi0) << sh;
    end

    vdlw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.norm),
        .i_num   (num),
        .i_den   (lo0),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    assign thr      = (r_d < SMALL_DEN) ? SMALL_LIMIT : WORD_W'(r_d);
    assign shr_done = !((r_lo >= thr) || (r_hi >= SPEED_LIMIT));
    assign lo_f     = (r_lo == '0) ? WORD_W'(1) : r_lo;
    assign sx       = r_xg ? r_hi : lo_f;
    assign sy       = r_xg ? lo_f : r_hi;

    // Write position of the drawing frame and its wrapped successor
    always_comb begin
        wp      = r_frame ? r_wp1 : r_wp0;
        base    = r_frame ? BASE1 : '0;
        off     = wp - base;
        off2    = {1'b0, off} + (ADDR_W + 1)'(2);
        if (off2 >= FSIZE) begin
            off2 = off2 - FSIZE;
        end
        wp_next = base + off2[ADDR_W-1:0];
    end

    always_comb begin
        raw = WORD_BLANK;
        case (r_op)
            OP_SWAP: begin
                // idx 0 sees the old frame, idx 1 the flipped one
                if (i_cmd.idx == IDX_MOVE) begin
                    raw = WORD_JUMP | WORD_W'(base);
                end else begin
                    raw = WORD_JUMP | WORD_W'(r_frame ? ADDR_W'(0) : BASE1);
                end
            end
            OP_LINE: begin
                case (i_cmd.idx)
                    IDX_MOVE:    raw = WORD_MOVE | WORD_W'(r_x);
                    IDX_BEAM:    raw = WORD_MOVE | WORD_W'(r_y);
                    IDX_SPEED_X: raw = sx;
                    default:     raw = sy;
                endcase
            end
            default: begin
                case (i_cmd.idx)
                    IDX_MOVE: raw = WORD_MOVE | WORD_W'(r_x);
                    IDX_BEAM: raw = WORD_W'(r_y);
                    default:  raw = WORD_BLANK;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x <= '0;
            r_pen_y <= '0;
            r_frame <= 1'b0;
            r_wp0   <= '0;
            r_wp1   <= BASE1;
        end else begin
            if (i_cmd.take && (i_operation == OP_MOVE || i_operation == OP_LINE)) begin
                r_pen_x <= i_x;
                r_pen_y <= i_y;
            end
            if (i_cmd.emit) begin
                if (r_op == OP_SWAP) begin
                    if (i_cmd.idx == IDX_MOVE) begin
                        r_frame <= ~r_frame;
                    end else if (r_frame) begin
                        r_wp1 <= BASE1;
                    end else begin
                        r_wp0 <= '0;
                    end
                end else if (r_frame) begin
                    r_wp1 <= wp_next;
                end else begin
                    r_wp0 <= wp_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op <= i_operation;
            r_x  <= i_x;
            r_y  <= i_y;
            r_dx <= dx;
            r_dy <= dy;
        end
        if (i_cmd.norm) begin
            r_xg <= xg;
            r_d  <= lo0;
            r_lo <= WORD_W'(1) << sh;
        end
        if (i_cmd.load_quot) begin
            r_hi <= quot;
        end else if (i_cmd.shr_step) begin
            r_hi <= r_hi >> 1;
            r_lo <= r_lo >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_address <= wp;
            r_word    <= {raw[7:0], raw[15:8]};
            r_last    <= i_cmd.last;
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.div_busy = div_busy;
    assign o_sts.shr_done = shr_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_address   = r_address;
    assign o_word      = r_word;
    assign o_last      = r_last;

endmodule

// ===== rtl/core/vdlw_ctrl.sv =====
// ----------------------------------------------------------------------------
// vdlw_ctrl
// Controller: sequences accept, normalize, divide, scale down and word output.
// ----------------------------------------------------------------------------
module vdlw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_operation,
    output logic           o_in_ready,
    output vdlw_pkg::t_cmd o_cmd,
    input  vdlw_pkg::t_sts i_sts
);
    import vdlw_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic       last;

    assign last = ((i_sts.op == OP_SWAP) && (r_idx == SWAP_LAST_IDX))
                  || (r_idx == CMD_LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_in_valid) begin
                    unique case (i_operation) inside
                        OP_LINE:          n_state = S_NORM;
                        OP_MOVE, OP_SWAP: n_state = S_EMIT;
                        default:          n_state = S_IDLE;
                    endcase
                end
            end
            S_NORM: n_state = S_DIV;
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_SHR;
                end
            end
            S_SHR: begin
                if (i_sts.shr_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_idx = r_idx + 1'b1;
                    if (last) begin
                        n_state = S_IDLE;
                        n_idx   = '0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.idx       = r_idx;
        o_cmd.last      = last;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            S_NORM: o_cmd.norm      = 1'b1;
            S_DIV:  o_cmd.load_quot = !i_sts.div_busy;
            S_SHR:  o_cmd.shr_step  = !i_sts.shr_done;
            S_EMIT: o_cmd.emit      = i_sts.out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

// ===== rtl/core/vdlw_checker.sv =====
// ----------------------------------------------------------------------------
// vdlw_checker
// Port-level checks of the vector display list writer, bound to the top level.
// ----------------------------------------------------------------------------
module vdlw_checker #(
    parameter int FRAME_BYTES = 512
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [1:0]                   i_operation,
    input logic [vdlw_pkg::COORD_W-1:0] i_x,
    input logic [vdlw_pkg::COORD_W-1:0] i_y,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [vdlw_pkg::ADDR_W-1:0]  o_address,
    input logic [vdlw_pkg::WORD_W-1:0]  o_word,
    input logic                         o_last
);
    import vdlw_pkg::*;

    localparam logic [ADDR_W:0] ADDR_END = (ADDR_W + 1)'(2 * FRAME_BYTES);

    // Hold a stalled word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_address) && $stable(o_word) && $stable(o_last))
        else $error("stalled output word changed");

    // A request that makes words blocks the next one
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready
            && (i_operation == OP_MOVE || i_operation == OP_LINE
                || i_operation == OP_SWAP)
        |=> !o_in_ready)
        else $error("input ready while request words are pending");

    // Only a final word may still wait while ready for a new request
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_in_ready |-> o_last)
        else $error("non-final word pending while idle");

    // Addresses stay inside the two frames
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_address} < ADDR_END))
        else $error("address outside display memory");

endmodule

bind vector_display_list_writer vdlw_checker #(
    .FRAME_BYTES (FRAME_BYTES)
) u_vdlw_checker (.*);

// ===== tb/vector_display_list_writer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_display_list_writer_tb
// Drives move, line, swap and unused requests into the display list writer,
// predicts every display word with its address and last flag, and checks the
// words in order while both handshakes idle at random.
// ----------------------------------------------------------------------------
module vector_display_list_writer_tb;

    import vdlw_pkg::*;

    localparam int          FRAME_BYTES = 512;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int unsigned NORM_FLOOR  = 32'h8000;
    localparam int unsigned COORD_MAX   = 1023;
    localparam int          MAX_REPORTS = 10;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] word;
        logic              last;
    } t_display_word;

    // Tracks pen, frame select and write positions; queues the display words
    // that each accepted request must produce.
    class display_list_checker;
        int unsigned   pen_x;
        int unsigned   pen_y;
        int unsigned   frame;
        int unsigned   wpos[2];
        t_display_word pending_words[$];
        int            mismatches;

        function new();
            pen_x = 0;
            pen_y = 0;
            frame = 0;
            wpos[0] = 0;
            wpos[1] = FRAME_BYTES & COORD_MAX;
            mismatches = 0;
        endfunction

        function int unsigned frame_start(int unsigned f);
            return f ? FRAME_BYTES : 0;
        endfunction

        function void queue_word(logic [WORD_W-1:0] raw, logic is_last);
            t_display_word w;
            w.address = ADDR_W'(wpos[frame] & COORD_MAX);
            w.word    = {raw[7:0], raw[15:8]};
            w.last    = is_last;
            pending_words.push_back(w);
        endfunction

        // Advance the current frame's position by one word, wrapping in the frame
        function void bump_position();
            int unsigned base;
            int unsigned off;
            base = frame_start(frame);
            off = (wpos[frame] - base) & 32'hffff;
            off = (off + 2) % FRAME_BYTES;
            wpos[frame] = (base + off) & COORD_MAX;
        endfunction

        function void speed_pair(int unsigned dx, int unsigned dy,
                                 output int unsigned sx, output int unsigned sy);
            bit          x_major;
            int unsigned hi;
            int unsigned lo;
            int unsigned den;
            int unsigned thr;
            x_major = dx > dy;
            hi = x_major ? dx : dy;
            lo = x_major ? dy : dx;
            if (hi == 0) hi = 1;
            if (lo == 0) lo = hi;
            den = lo;
            while (hi < NORM_FLOOR) begin
                hi = hi << 1;
                lo = lo << 1;
            end
            hi = hi / den;
            lo = lo / den;
            thr = (den < SMALL_DEN) ? SMALL_LIMIT : den;
            while (lo >= thr || hi >= SPEED_LIMIT) begin
                hi = hi >> 1;
                lo = lo >> 1;
            end
            if (lo == 0) lo = 1;
            sx = x_major ? hi : lo;
            sy = x_major ? lo : hi;
        endfunction

        function void note_request(logic [1:0] op, logic [COORD_W-1:0] x,
                                   logic [COORD_W-1:0] y);
            int unsigned      dx;
            int unsigned      dy;
            int unsigned      sx;
            int unsigned      sy;
            logic [WORD_W-1:0] target;
            if (op == OP_LINE) begin
                dx = (x > pen_x) ? x - pen_x : pen_x - x;
                dy = (y > pen_y) ? y - pen_y : pen_y - y;
                speed_pair(dx, dy, sx, sy);
                pen_x = x;
                pen_y = y;
                queue_word(WORD_MOVE | x, 1'b0); bump_position();
                queue_word(WORD_MOVE | y, 1'b0); bump_position();
                queue_word(sx[WORD_W-1:0], 1'b0); bump_position();
                queue_word(sy[WORD_W-1:0], 1'b1); bump_position();
            end else if (op == OP_MOVE) begin
                pen_x = x;
                pen_y = y;
                queue_word(WORD_MOVE | x, 1'b0); bump_position();
                queue_word({6'd0, y}, 1'b0); bump_position();
                queue_word(WORD_BLANK, 1'b0); bump_position();
                queue_word(WORD_BLANK, 1'b1); bump_position();
            end else if (op == OP_SWAP) begin
                // Jump to the old frame's start, written into both frames
                target = WORD_JUMP | WORD_W'(frame_start(frame));
                queue_word(target, 1'b0);
                frame = frame ^ 1;
                queue_word(target, 1'b1);
                wpos[frame] = frame_start(frame);
            end
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("%t: %s", $realtime, msg);
        endfunction

        function void check_word(logic [ADDR_W-1:0] address, logic [WORD_W-1:0] word,
                                 logic last);
            t_display_word w;
            if (pending_words.size() == 0) begin
                flag($sformatf("unexpected word addr=%0d word=%h last=%b",
                               address, word, last));
                return;
            end
            w = pending_words.pop_front();
            if (address !== w.address)
                flag($sformatf("address: expected %0d, got %0d", w.address, address));
            if (word !== w.word)
                flag($sformatf("word at %0d: expected %h, got %h", w.address, w.word, word));
            if (last !== w.last)
                flag($sformatf("last at %0d: expected %b, got %b", w.address, w.last, last));
        endfunction

        function int pending();
            return pending_words.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         in_operation = 2'd0;
    logic [COORD_W-1:0] in_x = '0;
    logic [COORD_W-1:0] in_y = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [ADDR_W-1:0]  out_address;
    logic [WORD_W-1:0]  out_word;
    logic               out_last;

    display_list_checker checker_h;
    bit                  no_idle = 1'b0;
    int                  stall_left = 0;

    vector_display_list_writer #(
        .FRAME_BYTES(FRAME_BYTES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_operation(in_operation),
        .i_x        (in_x),
        .i_y        (in_y),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_address  (out_address),
        .o_word     (out_word),
        .o_last     (out_last)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Take words where valid and ready meet; drive ready with random stalls
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            checker_h.check_word(out_address, out_word, out_last);
        if (no_idle) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
        end
    end

    // Hold the request until accepted; drop valid only when a gap follows
    task automatic send_request(input logic [1:0] op, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_operation <= op;
        in_x         <= x;
        in_y         <= y;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        checker_h.note_request(op, x, y);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(int unsigned pen);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return COORD_W'(COORD_MAX);
        if (r < 40) begin
            v = int'(pen) + $urandom_range(0, 40) - 20;
            if (v < 0) v = 0;
            if (v > COORD_MAX) v = COORD_MAX;
            return COORD_W'(v);
        end
        return COORD_W'($urandom_range(0, COORD_MAX));
    endfunction

    task automatic random_request(input bit allow_swap);
        int         r;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        if (allow_swap && r < 8) op = OP_SWAP;
        else if (r < 11) op = OP_UNUSED;
        else if (r < 40) op = OP_MOVE;
        else op = OP_LINE;
        send_request(op, pick_coord(checker_h.pen_x), pick_coord(checker_h.pen_y));
    endtask

    initial begin
        checker_h = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero deltas, single-axis extremes, equal deltas, tiny and
        // lopsided deltas, a large divisor, the unused code and both frames
        send_request(OP_LINE, 10'd0, 10'd0);
        send_request(OP_LINE, 10'd1023, 10'd0);
        send_request(OP_LINE, 10'd1023, 10'd1023);
        send_request(OP_LINE, 10'd0, 10'd0);
        send_request(OP_MOVE, 10'd1023, 10'd1023);
        send_request(OP_LINE, 10'd1022, 10'd1020);
        send_request(OP_LINE, 10'd0, 10'd1019);
        send_request(OP_LINE, 10'd300, 10'd700);
        send_request(OP_LINE, 10'd301, 10'd700);
        send_request(OP_UNUSED, 10'd1023, 10'd1023);
        send_request(OP_UNUSED, 10'd0, 10'd0);
        send_request(OP_SWAP, 10'd1023, 10'd1023);
        send_request(OP_MOVE, 10'd0, 10'd0);
        send_request(OP_LINE, 10'd5, 10'd517);
        send_request(OP_SWAP, 10'd0, 10'd0);
        send_request(OP_SWAP, 10'd512, 10'd512);
        send_request(OP_LINE, 10'd1023, 10'd1);
        send_request(OP_MOVE, 10'd512, 10'd511);
        send_request(OP_SWAP, 10'd0, 10'd0);
        send_request(OP_SWAP, 10'd0, 10'd0);

        // Random: a long swap-free run first so positions wrap in one frame,
        // then mixed traffic; idling is switched off for some stretches
        for (int i = 0; i < 370; i++) begin
            if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            random_request(i >= 150);
        end
        in_valid <= 1'b0;
        no_idle = 1'b0;

        while (checker_h.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #1_500_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
